/* hdl/lagtrg_pkg.sv */
// shared types, constants and index helpers for the lagged-table generator
// no dependencies
`default_nettype none

package lagtrg_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int WORD_W = 32;

	localparam logic [16:0] LCG_FACTOR = 17'd67397;
	localparam logic [WORD_W-1:0] LCG_OFFSET = 32'd7364893;

	localparam logic [IDX_W-1:0] LAG_A = IDX_W'(24);
	localparam logic [IDX_W-1:0] LAG_B = IDX_W'(55);
	localparam logic [IDX_W-1:0] LAG_C = IDX_W'(61);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	// input word kind
	localparam logic KIND_DRAW   = 1'b0;
	localparam logic KIND_RESEED = 1'b1;

	// read tap select
	localparam logic [1:0] SEL_A = 2'd0;
	localparam logic [1:0] SEL_B = 2'd1;
	localparam logic [1:0] SEL_C = 2'd2;

	typedef struct packed {
		logic       load_seed;
		logic       fill_step;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       cap_a;
		logic       cap_b;
		logic       finish;
	} lagtrg_cmd_t;

	typedef struct packed {
		logic fill_last;
		logic out_free;
	} lagtrg_sts_t;

	// position lag entries behind pos, modulo the table depth
	function automatic logic [IDX_W-1:0] back_from(input logic [IDX_W-1:0] pos,
			input logic [IDX_W-1:0] lag);
		return (pos >= lag) ? IDX_W'(pos - lag)
			: IDX_W'(pos + IDX_W'(LAST_IDX - lag) + 1'b1);
	endfunction

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] pos);
		return (pos == LAST_IDX) ? '0 : IDX_W'(pos + 1'b1);
	endfunction

endpackage

`default_nettype wire

/* hdl/lagtrg_ram.sv */
// generic single write, single read RAM with registered read data
// no dependencies
`default_nettype none

module lagtrg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* hdl/lagtrg_dp.sv */
// datapath: index, recurrence register, tap captures, output word register
// depends on lagtrg_pkg and lagtrg_ram
`default_nettype none

module lagtrg_dp
	import lagtrg_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lagtrg_cmd_t        cmd,
	output lagtrg_sts_t             sts,
	input  wire logic signed [31:0] seed_value,
	output logic             [31:0] random_word,
	output logic                    out_valid,
	input  wire logic               out_ready
);

	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  cnt_q;
	logic [WORD_W-1:0] fill_q;
	logic              seeded_q;
	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] b_q;
	logic [WORD_W-1:0] word_q;
	logic              out_valid_q;

	logic [WORD_W-1:0] fill_next;
	logic [WORD_W-1:0] rd_data;
	logic [WORD_W-1:0] tap;
	logic [WORD_W-1:0] sum;
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic              wr_en;

	assign fill_next = WORD_W'(fill_q * LCG_FACTOR) + LCG_OFFSET;

	// before the first reseed every tap reads as zero
	assign tap = seeded_q ? rd_data : '0;
	assign sum = a_q + b_q;

	always_comb begin
		case (cmd.rd_sel)
			SEL_A:   rd_addr = back_from(idx_q, LAG_A);
			SEL_B:   rd_addr = back_from(idx_q, LAG_B);
			SEL_C:   rd_addr = back_from(idx_q, LAG_C);
			default: rd_addr = idx_q;
		endcase
	end

	assign wr_en   = cmd.fill_step || cmd.finish;
	assign wr_addr = cmd.fill_step ? cnt_q : idx_q;
	assign wr_data = cmd.fill_step ? fill_next : sum;

	lagtrg_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			cnt_q       <= '0;
			fill_q      <= '0;
			seeded_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_seed) begin
				fill_q <= $unsigned(seed_value);
				cnt_q  <= '0;
			end else if (cmd.fill_step) begin
				fill_q <= fill_next;
				cnt_q  <= next_idx(cnt_q);
				if (sts.fill_last) begin
					idx_q    <= '0;
					seeded_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				idx_q       <= next_idx(idx_q);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_a) begin
			a_q <= tap;
		end
		if (cmd.cap_b) begin
			b_q <= tap;
		end
		if (cmd.finish) begin
			word_q <= sum ^ tap;
		end
	end

	assign sts.fill_last = (cnt_q == LAST_IDX);
	assign sts.out_free  = !out_valid_q || out_ready;
	assign random_word   = word_q;
	assign out_valid     = out_valid_q;

	a_fill_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_step && sts.fill_last |=> idx_q == '0 && seeded_q)
		else $error("fill end did not rewind index");

	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q && idx_q == next_idx($past(idx_q)))
		else $error("finish did not present word and advance index");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("output word overwritten");

endmodule

`default_nettype wire

/* hdl/lagtrg_ctrl.sv */
// controller: sequences table fill on reseed and the three tap reads of a draw
// depends on lagtrg_pkg
`default_nettype none

module lagtrg_ctrl
	import lagtrg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	output lagtrg_cmd_t      cmd,
	input  wire lagtrg_sts_t sts
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FILL = 3'd1;
	localparam logic [2:0] ST_RD_B = 3'd2;
	localparam logic [2:0] ST_RD_C = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && kind == KIND_RESEED) begin
					cmd.load_seed = 1'b1;
					state_d       = ST_FILL;
				end else if (accept) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = SEL_A;
					state_d    = ST_RD_B;
				end
			end
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_RD_B: begin
				cmd.cap_a  = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = SEL_B;
				state_d    = ST_RD_C;
			end
			ST_RD_C: begin
				cmd.cap_b  = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = SEL_C;
				state_d    = ST_FIN;
			end
			ST_FIN: begin
				// third tap held in the RAM read register until the output frees
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_draw_seq: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == KIND_DRAW |=> state_q == ST_RD_B ##1 state_q == ST_RD_C
			##1 state_q == ST_FIN)
		else $error("draw read sequence broken");

	a_fill_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL |=> state_q == ST_FILL || state_q == ST_IDLE)
		else $error("fill left to wrong state");

	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && !sts.out_free |=> state_q == ST_FIN)
		else $error("draw left final state while output busy");

endmodule

`default_nettype wire

/* hdl/lagged_table_random_generator.sv */
// top level of the lagged-table random generator
// draw: taps A, B, C read in turn, word then registered; the next item is taken after it
// one draw at a time, as the three tap reads share the single RAM read port
// reseed: seed load, then one recurrence step and table write per cycle, no word produced
// reset: asynchronous, index zero, table reads as all zeros until the first reseed
// depends on lagtrg_pkg, lagtrg_ctrl, lagtrg_dp, lagtrg_ram
`default_nettype none

module lagged_table_random_generator
	import lagtrg_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input word channel
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               kind,
	input  wire logic signed [31:0] seed_value,
	// output word channel
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic             [31:0] random_word
);

	// command and status between sequencer and datapath
	lagtrg_cmd_t cmd;
	lagtrg_sts_t sts;

	// sequencer: reseed fill walk, draw tap reads, final write and output
	lagtrg_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind    (kind),
		.cmd     (cmd),
		.sts     (sts)
	);

	// datapath: table RAM, recurrence, lag taps and the output word register
	lagtrg_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.seed_value (seed_value),
		.random_word(random_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

endmodule

`default_nettype wire

/* sim/lagged_table_random_generator_tb.sv */
// testbench for the lagged-table random generator: directed and random word streams,
// each draw checked against an in-bench copy of the lag table
// depends on lagtrg_pkg and the lagged_table_random_generator top level
module lagged_table_random_generator_tb;
	import lagtrg_pkg::*;

	// recurrence and tap distances of the shadow model
	localparam logic [31:0] FILL_MUL = 32'd67397;
	localparam logic [31:0] FILL_ADD = 32'd7364893;
	localparam int TAP_SUM_A = 24;
	localparam int TAP_SUM_B = 55;
	localparam int TAP_MIX   = 61;

	localparam int ITEM_TARGET  = 950;
	localparam int IDLE_PCT     = 23;
	localparam int HOLD_CYCLES  = 150;
	// a reseed walks the whole table, so the tail covers one full fill
	localparam int DRAIN_CYCLES = 300;
	localparam int STALL_LIMIT  = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = KIND_DRAW;
	logic signed [31:0] seed_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] random_word;

	// receiver controls, written nonblocking by the tests
	logic calm = 1'b0;
	int hold_asked = 0;
	int hold_taken = 0;
	int hold_left = 0;

	// shadow of the generator state
	logic [31:0] shadow_words [TABLE_DEPTH];
	int shadow_pos = 0;
	logic [31:0] expected_words [$];

	int words_sent = 0;
	int reseeds_sent = 0;
	int draws_checked = 0;
	int mismatch_count = 0;

	lagged_table_random_generator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.seed_value  (seed_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.random_word (random_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// advance the shadow table by one word; returns 1 when a draw result is due
	function automatic bit step_shadow(input logic k, input logic [31:0] s,
			output logic [31:0] word);
		logic [31:0] fill;
		logic [31:0] total;
		int pos;
		word = '0;
		if (k == KIND_RESEED) begin
			// entry i holds the value after i+1 recurrence steps
			fill = s;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				fill = fill * FILL_MUL + FILL_ADD;
				shadow_words[i] = fill;
			end
			shadow_pos = 0;
			return 1'b0;
		end
		pos = shadow_pos;
		total = shadow_words[(pos + TABLE_DEPTH - TAP_SUM_A) % TABLE_DEPTH]
			+ shadow_words[(pos + TABLE_DEPTH - TAP_SUM_B) % TABLE_DEPTH];
		shadow_words[pos] = total;
		word = total ^ shadow_words[(pos + TABLE_DEPTH - TAP_MIX) % TABLE_DEPTH];
		shadow_pos = (pos + 1) % TABLE_DEPTH;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// offer one word and wait for it to be taken; valid stays up into the next word
	task automatic send_word(input logic k, input logic [31:0] s, input bit eager);
		logic [31:0] word;
		if (!eager) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		kind <= k;
		seed_value <= s;
		do @(posedge clk); while (in_ready !== 1'b1);
		if (step_shadow(k, s, word))
			expected_words.push_back(word);
		else
			reseeds_sent++;
		words_sent++;
	endtask

	// receiver: random stalls, steady mode, or one long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_asked != hold_taken) begin
			out_ready <= 1'b0;
			hold_taken <= hold_asked;
			hold_left <= HOLD_CYCLES - 1;
		end else if (calm) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// every taken result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("random_word %08h with no draw pending",
					random_word));
			end else begin
				if (random_word !== expected_words[0])
					report_mismatch($sformatf("draw %0d: random_word %08h, predicted %08h",
						draws_checked, random_word, expected_words[0]));
				void'(expected_words.pop_front());
				draws_checked++;
			end
		end
	end

	// watchdog on cycles where no word moves on either side
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
		$display("[lagged_table_random_generator] ERROR");
		$finish;
	end

	// before any reseed the table is zero, so draws answer zero
	task automatic test_draw_from_reset();
		repeat (4) send_word(KIND_DRAW, $urandom, 1'b0);
	endtask

	// most negative, most positive, minus one, zero and one as seeds
	task automatic test_seed_extremes();
		logic [31:0] seeds [5] = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
			32'h0000_0000, 32'h0000_0001};
		foreach (seeds[i]) begin
			send_word(KIND_RESEED, seeds[i], 1'b0);
			send_word(KIND_DRAW, ~seeds[i], 1'b0);
		end
	endtask

	// second reseed must fully replace the first
	task automatic test_double_reseed();
		send_word(KIND_RESEED, $urandom, 1'b0);
		send_word(KIND_RESEED, $urandom, 1'b0);
		send_word(KIND_DRAW, $urandom, 1'b0);
	endtask

	// receiver holds off while draws keep coming, so the input stalls
	task automatic test_output_backpressure();
		hold_asked <= hold_asked + 1;
		repeat (8) send_word(KIND_DRAW, $urandom, 1'b1);
	endtask

	// no idling on either side, long enough to wrap the index
	task automatic test_steady_stream();
		calm <= 1'b1;
		send_word(KIND_RESEED, $urandom, 1'b1);
		repeat (300) send_word(KIND_DRAW, $urandom, 1'b1);
		calm <= 1'b0;
	endtask

	// mostly reseed-then-draw runs, some past the wrap, plus stray reseeds and draw runs
	task automatic test_random_sequences();
		int pick;
		int run;
		while (words_sent < ITEM_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_word(KIND_RESEED, $urandom, 1'b0);
			end else if (pick < 20) begin
				repeat ($urandom_range(1, 40))
					if (words_sent < ITEM_TARGET) send_word(KIND_DRAW, $urandom, 1'b0);
			end else begin
				send_word(KIND_RESEED, $urandom, 1'b0);
				run = (pick < 30) ? $urandom_range(257, 320) : $urandom_range(1, 80);
				repeat (run)
					if (words_sent < ITEM_TARGET) send_word(KIND_DRAW, $urandom, 1'b0);
			end
		end
	endtask

	initial begin
		foreach (shadow_words[i]) shadow_words[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_draw_from_reset();
		test_seed_extremes();
		test_double_reseed();
		test_output_backpressure();
		test_steady_stream();
		test_random_sequences();

		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d words, %0d of them reseeds, %0d draws checked",
			words_sent, reseeds_sent, draws_checked);
		$display("including seed extremes, index wrap and a %0d-cycle output hold-off",
			HOLD_CYCLES);
		if (mismatch_count == 0) begin
			$display("[lagged_table_random_generator] OK");
		end else begin
			$display("[lagged_table_random_generator] ERROR");
		end
		$finish;
	end

endmodule

/* lagged_table_random_generator.f */
hdl/lagtrg_pkg.sv
hdl/lagtrg_ram.sv
hdl/lagtrg_dp.sv
hdl/lagtrg_ctrl.sv
hdl/lagged_table_random_generator.sv
sim/lagged_table_random_generator_tb.sv
